// ===== design/roe_pkg.sv =====
// Shared types, constants and saturating helpers for the isothermal Roe flux block.
package roe_pkg;

  typedef logic signed [63:0] wide_t;

  localparam int RHO_W = 31;
  localparam int VEL_W = 32;
  localparam int CFG_W = 31;

  // quotient bits kept by the divider; the clamp limit is 2^62 - 1
  localparam int QBITS   = 62;
  localparam int DIV_LAT = QBITS + 2;

  localparam wide_t SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_HI = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LO = -SAT_HI;

  // register index, taken from paddr[2]
  localparam logic REG_SOUND_SPEED = 1'b0;

  typedef struct packed {
    logic spc;   // result fixed, no quotient needed
    logic zero;  // fixed result is zero
    logic neg;   // fixed result is negative
  } roe_dflag_t;

  function automatic wide_t sat65(logic signed [64:0] s);
    wide_t r;
    if (s > SAT_HI) begin
      r = SAT_LIM;
    end else if (s < SAT_LO) begin
      r = -SAT_LIM;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic wide_t sat_add(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return sat65(s);
  endfunction

  function automatic wide_t sat_sub(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return sat65(s);
  endfunction

  function automatic logic [63:0] mag_w(wide_t a);
    logic [63:0] m;
    m = a[63] ? 64'd0 - 64'(a) : 64'(a);
    return m;
  endfunction

  function automatic wide_t abs_w(wide_t a);
    wide_t r;
    r = a[63] ? -a : a;
    return r;
  endfunction

  // divide by two, truncating toward zero
  function automatic wide_t half_w(wide_t a);
    wide_t r;
    r = (a + wide_t'({63'd0, a[63]})) >>> 1;
    return r;
  endfunction

endpackage

// ===== design/roe_dly.sv =====
// Enabled delay line for aligning side data with the arithmetic units.
module roe_dly #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

// ===== design/roe_mul.sv =====
// Two-stage saturating fixed-point multiplier built from four 32x32 partial products.
module roe_mul import roe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  en,
  input  wide_t a,
  input  wide_t b,
  output wide_t p
);

  logic [63:0]  ua, ub;
  logic [63:0]  pp [4];
  logic         neg;
  logic [127:0] full, shifted;
  logic [61:0]  m;
  wide_t        mv;

  assign ua = mag_w(a);
  assign ub = mag_w(b);

  always_ff @(posedge clk) begin
    if (en) begin
      pp[0] <= ua[31:0]  * ub[31:0];
      pp[1] <= ua[31:0]  * ub[63:32];
      pp[2] <= ua[63:32] * ub[31:0];
      pp[3] <= ua[63:32] * ub[63:32];
      neg   <= a[63] ^ b[63];
    end
  end

  always_comb begin
    full    = {64'd0, pp[0]} + {32'd0, pp[1], 32'd0} + {32'd0, pp[2], 32'd0}
            + {pp[3], 64'd0};
    shifted = full >> FRAC_BITS;
    m       = (|shifted[127:62]) ? SAT_LIM[61:0] : shifted[61:0];
    mv      = {2'b00, m};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? -mv : mv;
    end
  end

endmodule

// ===== design/roe_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module roe_sqrt #(
  parameter int IN_W = 47,
  localparam int ROOT_W = (IN_W + 1) / 2
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   x,
  output logic [ROOT_W-1:0] root
);

  localparam int XE = 2 * ROOT_W;

  logic [XE-1:0] rem_q [ROOT_W];
  logic [XE-1:0] res_q [ROOT_W];
  logic [XE-1:0] rem_in [ROOT_W];
  logic [XE-1:0] res_in [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [XE:0] BIT = (XE+1)'(1) << (2 * (ROOT_W - 1 - k));
    logic [XE:0] trial;

    if (k == 0) begin : g_first
      assign rem_in[k] = XE'(x);
      assign res_in[k] = '0;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign res_in[k] = res_q[k-1];
    end

    assign trial = {1'b0, res_in[k]} + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in[k]} >= trial) begin
          rem_q[k] <= rem_in[k] - trial[XE-1:0];
          res_q[k] <= (res_in[k] >> 1) + BIT[XE-1:0];
        end else begin
          rem_q[k] <= rem_in[k];
          res_q[k] <= res_in[k] >> 1;
        end
      end
    end
  end

  assign root = res_q[ROOT_W-1][ROOT_W-1:0];

endmodule

// ===== design/roe_div.sv =====
// Pipelined saturating fixed-point divider, restoring, one quotient bit per stage.
module roe_div import roe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  en,
  input  wide_t num,
  input  wide_t den,
  output wide_t quo
);

  logic [63:0]      un, ud, r0;
  logic             neg;
  roe_dflag_t       flg0;

  logic [63:0]      rem_q [QBITS+1];
  logic [QBITS-1:0] q_q   [QBITS+1];
  logic [QBITS-1:0] nb_q  [QBITS+1];
  logic [63:0]      ud_q  [QBITS+1];
  roe_dflag_t       flg_q [QBITS+1];

  wide_t            qv;

  always_comb begin
    un  = mag_w(num);
    ud  = mag_w(den);
    neg = num[63] ^ den[63];
    r0  = un >> (QBITS - FRAC_BITS);
    // zero divisor, or integer part too large for the clamp range
    flg0.spc  = (ud == 64'd0) || (r0 >= ud);
    flg0.zero = (ud == 64'd0) && (num == 64'sd0);
    flg0.neg  = (ud == 64'd0) ? num[63] : neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= r0;
      q_q[0]   <= '0;
      nb_q[0]  <= {un[QBITS-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      ud_q[0]  <= ud;
      flg_q[0] <= flg0;
    end
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_step
    logic [63:0] r2;
    assign r2 = {rem_q[i-1][62:0], nb_q[i-1][QBITS-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= ud_q[i-1]) begin
          rem_q[i] <= r2 - ud_q[i-1];
          q_q[i]   <= {q_q[i-1][QBITS-2:0], 1'b1};
        end else begin
          rem_q[i] <= r2;
          q_q[i]   <= {q_q[i-1][QBITS-2:0], 1'b0};
        end
        nb_q[i]  <= {nb_q[i-1][QBITS-2:0], 1'b0};
        ud_q[i]  <= ud_q[i-1];
        flg_q[i] <= flg_q[i-1];
      end
    end
  end

  assign qv = {2'b00, q_q[QBITS]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg_q[QBITS].spc) begin
        if (flg_q[QBITS].zero) begin
          quo <= '0;
        end else begin
          quo <= flg_q[QBITS].neg ? -SAT_LIM : SAT_LIM;
        end
      end else begin
        quo <= flg_q[QBITS].neg ? -qv : qv;
      end
    end
  end

endmodule

// ===== design/roe_isothermal_interface_flux.sv =====
// Top level: Roe numerical flux for isothermal 2D Euler flow at one cell interface.
//
//  port group   direction  handshake                 payload
//  item         in         item_valid / item_stall   rho/u/v left and right
//  result       out        result_valid / result_stall  three fluxes, invalid
//  apb          in/out     psel, penable, pready     sound_speed at byte 0
//
// One beat in and one beat out per cycle, sustained while no result beat is held
// by result_stall. An accepted item beat reaches its result beat through the density
// square roots, two 64-stage dividers in series and the multiplies.
// Reset clears the valid chain and loads sound_speed with 2.0; data regs are not reset.
// The whole pipe advances together; it freezes only while a result beat is held
// by result_stall, and item_stall follows that freeze.
module roe_isothermal_interface_flux import roe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // item channel
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [RHO_W-1:0]        rho_left,
  input  logic signed [VEL_W-1:0] u_left,
  input  logic signed [VEL_W-1:0] v_left,
  input  logic [RHO_W-1:0]        rho_right,
  input  logic signed [VEL_W-1:0] u_right,
  input  logic signed [VEL_W-1:0] v_right,
  // result channel
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [31:0]      flux_mass,
  output logic signed [31:0]      flux_normal_momentum,
  output logic signed [31:0]      flux_tangential_momentum,
  output logic                    invalid,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int RHO_X  = RHO_W + FRAC_BITS;
  localparam int ROOT_W = (RHO_X + 1) / 2;
  // time points, counted in stages after the input register
  localparam int TU     = ROOT_W + 3 + DIV_LAT;   // Roe velocities ready
  localparam int TV     = TU + 4 + DIV_LAT;       // wave strengths ready
  localparam int NV     = TV + 8;                 // valid chain length
  localparam logic [CFG_W-1:0] SS_RESET = CFG_W'(64'd2 << FRAC_BITS);

  function automatic wide_t sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic wide_t zx31(logic [RHO_W-1:0] v);
    return {33'd0, v};
  endfunction

  function automatic logic [31:0] clamp32(wide_t a, wide_t b);
    logic signed [64:0] df;
    logic [31:0]        r;
    df = {a[63], a} - {b[63], b};
    if (df > 65'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (df < -65'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = df[31:0];
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] sound_speed;
  wide_t            c_w, twoc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_speed <= SS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SOUND_SPEED) begin
      sound_speed <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SOUND_SPEED) ? {1'b0, sound_speed} : 32'd0;
  // a zero sound speed acts as one LSB
  assign c_w    = (sound_speed == '0) ? 64'sd1 : zx31(sound_speed);
  assign twoc   = {c_w[62:0], 1'b0};

  // ---------------- flow control ----------------
  logic          en;
  logic [NV-1:0] vld;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[NV-2:0], item_valid};
      result_valid <= vld[NV-1];
    end
  end

  // ---------------- T0: input register ----------------
  logic [RHO_W-1:0] rl0, rr0;
  logic [31:0]      ul0, vl0, ur0, vr0;
  logic             inv0;
  wide_t            d0_1;

  always_ff @(posedge clk) begin
    if (en) begin
      rl0  <= rho_left;
      rr0  <= rho_right;
      ul0  <= u_left;
      vl0  <= v_left;
      ur0  <= u_right;
      vr0  <= v_right;
      inv0 <= (rho_left == '0) || (rho_right == '0);
      d0_1 <= zx31(rr0) - zx31(rl0);
    end
  end

  logic [127:0] vel2, velk;

  roe_dly #(.WIDTH(128), .DEPTH(2)) u_vel2 (
    .clk(clk), .en(en), .d({ul0, vl0, ur0, vr0}), .q(vel2)
  );
  roe_dly #(.WIDTH(128), .DEPTH(ROOT_W)) u_velk (
    .clk(clk), .en(en), .d({ul0, vl0, ur0, vr0}), .q(velk)
  );

  // ---------------- multiplier groups ----------------
  // A (T0): rho*u, rho*v, rho*c for both sides
  wide_t ma_a [6], ma_b [6], ma_p [6];
  // B (T2): rho*u*u, rho*u*v, rho*c*c
  wide_t mb_a [6], mb_b [6], mb_p [6];
  // C (TK): sqrt(rho) weighted velocities
  wide_t mc_a [4], mc_b [4], mc_p [4];
  // D (TU+1): eigenvalue and tangential terms times the density jump
  wide_t md_a [3], md_b [3], md_p [3];
  // E (TV): wave strengths times eigenvalue magnitudes
  wide_t me_a [3], me_b [3], me_p [3];
  // F (TV+2): eigenvector components
  wide_t mf_a [4], mf_b [4], mf_p [4];

  for (genvar g = 0; g < 6; g++) begin : g_ma
    roe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(ma_a[g]), .b(ma_b[g]), .p(ma_p[g])
    );
  end
  for (genvar g = 0; g < 6; g++) begin : g_mb
    roe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(mb_a[g]), .b(mb_b[g]), .p(mb_p[g])
    );
  end
  for (genvar g = 0; g < 4; g++) begin : g_mc
    roe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(mc_a[g]), .b(mc_b[g]), .p(mc_p[g])
    );
  end
  for (genvar g = 0; g < 3; g++) begin : g_md
    roe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(md_a[g]), .b(md_b[g]), .p(md_p[g])
    );
  end
  for (genvar g = 0; g < 3; g++) begin : g_me
    roe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(me_a[g]), .b(me_b[g]), .p(me_p[g])
    );
  end
  for (genvar g = 0; g < 4; g++) begin : g_mf
    roe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(mf_a[g]), .b(mf_b[g]), .p(mf_p[g])
    );
  end

  // ---------------- square roots ----------------
  logic [ROOT_W-1:0] sl_k, sr_k;

  roe_sqrt #(.IN_W(RHO_X)) u_sqrt_l (
    .clk(clk), .en(en), .x({rl0, {FRAC_BITS{1'b0}}}), .root(sl_k)
  );
  roe_sqrt #(.IN_W(RHO_X)) u_sqrt_r (
    .clk(clk), .en(en), .x({rr0, {FRAC_BITS{1'b0}}}), .root(sr_k)
  );

  // ---------------- pipeline data ----------------
  wide_t d1_3, d2_3, s0_3, f1l_5, f1r_5, s2_5, s1_6;
  wide_t sden_1, sden_3, numu, numv, um, vm;
  wide_t upc1, umc1, um1, vm1, aumc2, aupc2, aum2;
  wide_t d0_d, d1_d, d2_d, n0_4, n1_4, a2_4, a0, a1, a2_v;
  wide_t aumc_v, aupc_v, aum_v, umc_v, upc_v, vm_v;
  wide_t dis0_3, dis0_6, w2_5, dis1_5, t_5, dis1_6, dis2_6;
  wide_t s0_v, s1_v, s2_v;
  wide_t hs [3], hd [3];
  logic  inv_v;
  logic [127:0] d12_d;
  logic [191:0] abs_v, eig_v;

  always_comb begin
    ma_a[0] = zx31(rl0);  ma_b[0] = sx32(ul0);
    ma_a[1] = zx31(rr0);  ma_b[1] = sx32(ur0);
    ma_a[2] = zx31(rl0);  ma_b[2] = sx32(vl0);
    ma_a[3] = zx31(rr0);  ma_b[3] = sx32(vr0);
    ma_a[4] = zx31(rl0);  ma_b[4] = c_w;
    ma_a[5] = zx31(rr0);  ma_b[5] = c_w;

    mb_a[0] = ma_p[0];    mb_b[0] = sx32(vel2[127:96]);
    mb_a[1] = ma_p[1];    mb_b[1] = sx32(vel2[63:32]);
    mb_a[2] = ma_p[0];    mb_b[2] = sx32(vel2[95:64]);
    mb_a[3] = ma_p[1];    mb_b[3] = sx32(vel2[31:0]);
    mb_a[4] = ma_p[4];    mb_b[4] = c_w;
    mb_a[5] = ma_p[5];    mb_b[5] = c_w;

    mc_a[0] = wide_t'(sl_k); mc_b[0] = sx32(velk[127:96]);
    mc_a[1] = wide_t'(sr_k); mc_b[1] = sx32(velk[63:32]);
    mc_a[2] = wide_t'(sl_k); mc_b[2] = sx32(velk[95:64]);
    mc_a[3] = wide_t'(sr_k); mc_b[3] = sx32(velk[31:0]);

    md_a[0] = upc1;       md_b[0] = d0_d;
    md_a[1] = umc1;       md_b[1] = d0_d;
    md_a[2] = vm1;        md_b[2] = d0_d;

    me_a[0] = a0;         me_b[0] = aumc_v;
    me_a[1] = a1;         me_b[1] = aupc_v;
    me_a[2] = a2_v;       me_b[2] = aum_v;

    mf_a[0] = me_p[0];    mf_b[0] = umc_v;
    mf_a[1] = me_p[1];    mf_b[1] = upc_v;
    mf_a[2] = me_p[0];    mf_b[2] = vm_v;
    mf_a[3] = me_p[1];    mf_b[3] = vm_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // jumps and central-flux sums
      d1_3   <= sat_sub(ma_p[1], ma_p[0]);
      d2_3   <= sat_sub(ma_p[3], ma_p[2]);
      s0_3   <= sat_add(ma_p[0], ma_p[1]);
      f1l_5  <= sat_add(mb_p[0], mb_p[4]);
      f1r_5  <= sat_add(mb_p[1], mb_p[5]);
      s2_5   <= sat_add(mb_p[2], mb_p[3]);
      s1_6   <= sat_add(f1l_5, f1r_5);
      // Roe average numerators and denominator
      sden_1 <= wide_t'(sl_k) + wide_t'(sr_k);
      numu   <= sat_add(mc_p[0], mc_p[1]);
      numv   <= sat_add(mc_p[2], mc_p[3]);
      // eigenvalues
      upc1   <= sat_add(um, c_w);
      umc1   <= sat_sub(um, c_w);
      um1    <= um;
      vm1    <= vm;
      aumc2  <= abs_w(umc1);
      aupc2  <= abs_w(upc1);
      aum2   <= abs_w(um1);
      // wave strength numerators
      n0_4   <= sat_sub(md_p[0], d1_d);
      n1_4   <= sat_sub(d1_d, md_p[1]);
      a2_4   <= sat_sub(d2_d, md_p[2]);
      // dissipation
      dis0_3 <= sat_add(me_p[0], me_p[1]);
      dis1_5 <= sat_add(mf_p[0], mf_p[1]);
      t_5    <= sat_add(mf_p[2], mf_p[3]);
      dis1_6 <= dis1_5;
      dis2_6 <= sat_add(t_5, w2_5);
      // halves, then output
      hs[0]  <= half_w(s0_v);
      hs[1]  <= half_w(s1_v);
      hs[2]  <= half_w(s2_v);
      hd[0]  <= half_w(dis0_6);
      hd[1]  <= half_w(dis1_6);
      hd[2]  <= half_w(dis2_6);
      flux_mass                <= inv_v ? 32'sd0 : clamp32(hs[0], hd[0]);
      flux_normal_momentum     <= inv_v ? 32'sd0 : clamp32(hs[1], hd[1]);
      flux_tangential_momentum <= inv_v ? 32'sd0 : clamp32(hs[2], hd[2]);
      invalid                  <= inv_v;
    end
  end

  // ---------------- dividers ----------------
  roe_div #(.FRAC_BITS(FRAC_BITS)) u_div_um (
    .clk(clk), .en(en), .num(numu), .den(sden_3), .quo(um)
  );
  roe_div #(.FRAC_BITS(FRAC_BITS)) u_div_vm (
    .clk(clk), .en(en), .num(numv), .den(sden_3), .quo(vm)
  );
  roe_div #(.FRAC_BITS(FRAC_BITS)) u_div_a0 (
    .clk(clk), .en(en), .num(n0_4), .den(twoc), .quo(a0)
  );
  roe_div #(.FRAC_BITS(FRAC_BITS)) u_div_a1 (
    .clk(clk), .en(en), .num(n1_4), .den(twoc), .quo(a1)
  );

  // ---------------- alignment delays ----------------
  roe_dly #(.WIDTH(64), .DEPTH(2)) u_sden (
    .clk(clk), .en(en), .d(sden_1), .q(sden_3)
  );
  roe_dly #(.WIDTH(64), .DEPTH(TU)) u_d0 (
    .clk(clk), .en(en), .d(d0_1), .q(d0_d)
  );
  roe_dly #(.WIDTH(128), .DEPTH(TU)) u_d12 (
    .clk(clk), .en(en), .d({d1_3, d2_3}), .q(d12_d)
  );
  assign d1_d = d12_d[127:64];
  assign d2_d = d12_d[63:0];

  roe_dly #(.WIDTH(64), .DEPTH(DIV_LAT)) u_a2 (
    .clk(clk), .en(en), .d(a2_4), .q(a2_v)
  );
  roe_dly #(.WIDTH(192), .DEPTH(DIV_LAT + 2)) u_abs (
    .clk(clk), .en(en), .d({aumc2, aupc2, aum2}), .q(abs_v)
  );
  assign aumc_v = abs_v[191:128];
  assign aupc_v = abs_v[127:64];
  assign aum_v  = abs_v[63:0];

  roe_dly #(.WIDTH(192), .DEPTH(DIV_LAT + 5)) u_eig (
    .clk(clk), .en(en), .d({umc1, upc1, vm1}), .q(eig_v)
  );
  assign umc_v = eig_v[191:128];
  assign upc_v = eig_v[127:64];
  assign vm_v  = eig_v[63:0];

  roe_dly #(.WIDTH(64), .DEPTH(3)) u_w2 (
    .clk(clk), .en(en), .d(me_p[2]), .q(w2_5)
  );
  roe_dly #(.WIDTH(64), .DEPTH(3)) u_dis0 (
    .clk(clk), .en(en), .d(dis0_3), .q(dis0_6)
  );
  roe_dly #(.WIDTH(64), .DEPTH(TV + 3)) u_s0 (
    .clk(clk), .en(en), .d(s0_3), .q(s0_v)
  );
  roe_dly #(.WIDTH(64), .DEPTH(TV)) u_s1 (
    .clk(clk), .en(en), .d(s1_6), .q(s1_v)
  );
  roe_dly #(.WIDTH(64), .DEPTH(TV + 1)) u_s2 (
    .clk(clk), .en(en), .d(s2_5), .q(s2_v)
  );
  roe_dly #(.WIDTH(1), .DEPTH(TV + 7)) u_inv (
    .clk(clk), .en(en), .d(inv0), .q(inv_v)
  );

endmodule

// ===== dv/roe_flux_checker.sv =====
// Checker for the isothermal Roe flux block: predicts each flux beat and compares it.
module roe_flux_checker import roe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic                    item_stall,
  input  logic [RHO_W-1:0]        rho_left,
  input  logic signed [VEL_W-1:0] u_left,
  input  logic signed [VEL_W-1:0] v_left,
  input  logic [RHO_W-1:0]        rho_right,
  input  logic signed [VEL_W-1:0] u_right,
  input  logic signed [VEL_W-1:0] v_right,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  logic signed [31:0]      flux_mass,
  input  logic signed [31:0]      flux_normal_momentum,
  input  logic signed [31:0]      flux_tangential_momentum,
  input  logic                    invalid,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] mass;
    logic signed [31:0] mom_n;
    logic signed [31:0] mom_t;
    logic               bad;
  } flux_t;

  flux_t flux_q[$];
  logic [CFG_W-1:0] csound;

  function automatic longint clip(longint x);
    if (x > LIM) return LIM;
    if (x < -LIM) return -LIM;
    return x;
  endfunction

  function automatic longint add_s(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint sub_s(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic logic [63:0] mag(longint a);
    return a < 0 ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  function automatic longint signed_mag(logic [63:0] m, logic neg);
    longint v;
    if (m > 64'(LIM)) m = 64'(LIM);
    v = longint'(m);
    return neg ? -v : v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    p = p >> FRAC_BITS;
    m = (p[127:64] != 0) ? 64'(LIM) : p[63:0];
    return signed_mag(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [63:0] un, ud, q, r;
    logic        neg;
    un = mag(n);
    ud = mag(d);
    neg = (n < 0) != (d < 0);
    if (ud == 0) return n == 0 ? 0 : (n < 0 ? -LIM : LIM);
    q = un / ud;
    r = un % ud;
    if (q > (64'(LIM) >> FRAC_BITS)) return signed_mag(64'(LIM), neg);
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q[0] = 1'b1;
      end
    end
    return signed_mag(q, neg);
  endfunction

  function automatic longint root_floor(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [31:0] to32(longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  function automatic flux_t roe_flux(longint rl, longint ul, longint vl,
                                     longint rr, longint ur, longint vr);
    flux_t  f;
    longint c, fl0, fl1, fl2, fr0, fr1, fr2, d0, d1, d2, sl, sr, um, vm;
    longint a0, a1, a2, w0, w1, w2, ds0, ds1, ds2, rul, rur;
    f = '{default: '0};
    if (rl == 0 || rr == 0) begin
      f.bad = 1'b1;
      return f;
    end
    c = (csound == 0) ? 1 : longint'(csound);
    rul = qmul(rl, ul);
    rur = qmul(rr, ur);
    fl0 = rul;
    fl1 = add_s(qmul(rul, ul), qmul(qmul(rl, c), c));
    fl2 = qmul(rul, vl);
    fr0 = rur;
    fr1 = add_s(qmul(rur, ur), qmul(qmul(rr, c), c));
    fr2 = qmul(rur, vr);
    d0 = rr - rl;
    d1 = sub_s(rur, rul);
    d2 = sub_s(qmul(rr, vr), qmul(rl, vl));
    sl = root_floor(64'(rl) << FRAC_BITS);
    sr = root_floor(64'(rr) << FRAC_BITS);
    um = qdiv(add_s(qmul(sl, ul), qmul(sr, ur)), sl + sr);
    vm = qdiv(add_s(qmul(sl, vl), qmul(sr, vr)), sl + sr);
    a0 = qdiv(sub_s(qmul(add_s(um, c), d0), d1), 2 * c);
    a1 = qdiv(sub_s(d1, qmul(sub_s(um, c), d0)), 2 * c);
    a2 = sub_s(d2, qmul(vm, d0));
    w0 = qmul(a0, mag(sub_s(um, c)));
    w1 = qmul(a1, mag(add_s(um, c)));
    w2 = qmul(a2, mag(um));
    ds0 = add_s(w0, w1);
    ds1 = add_s(qmul(w0, sub_s(um, c)), qmul(w1, add_s(um, c)));
    ds2 = add_s(add_s(qmul(w0, vm), qmul(w1, vm)), w2);
    f.mass  = to32(sub_s(add_s(fl0, fr0) / 2, ds0 / 2));
    f.mom_n = to32(sub_s(add_s(fl1, fr1) / 2, ds1 / 2));
    f.mom_t = to32(sub_s(add_s(fl2, fr2) / 2, ds2 / 2));
    return f;
  endfunction

  assign pending = flux_q.size();

  always @(posedge clk) begin
    flux_t exp_f;
    int    nerr;
    nerr = 0;
    if (rst) begin
      csound <= CFG_W'(2 << FRAC_BITS);
      errors <= 0;
      flux_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_SOUND_SPEED)
        csound <= pwdata[CFG_W-1:0];
      if (item_valid && !item_stall)
        flux_q.push_back(roe_flux(longint'(rho_left), longint'(u_left), longint'(v_left),
                                  longint'(rho_right), longint'(u_right),
                                  longint'(v_right)));
      if (result_valid && !result_stall) begin
        if (flux_q.size() == 0) begin
          $error("flux beat with nothing expected");
          nerr = nerr + 1;
        end else begin
          exp_f = flux_q.pop_front();
          if (flux_mass !== exp_f.mass) begin
            $error("flux_mass exp %0d got %0d", exp_f.mass, flux_mass);
            nerr = nerr + 1;
          end
          if (flux_normal_momentum !== exp_f.mom_n) begin
            $error("flux_normal_momentum exp %0d got %0d", exp_f.mom_n,
                   flux_normal_momentum);
            nerr = nerr + 1;
          end
          if (flux_tangential_momentum !== exp_f.mom_t) begin
            $error("flux_tangential_momentum exp %0d got %0d", exp_f.mom_t,
                   flux_tangential_momentum);
            nerr = nerr + 1;
          end
          if (invalid !== exp_f.bad) begin
            $error("invalid exp %0b got %0b", exp_f.bad, invalid);
            nerr = nerr + 1;
          end
        end
      end
      errors <= errors + nerr;
    end
  end
endmodule

// ===== dv/testbench.sv =====
// Top of the Roe flux testbench: clock, reset, stimulus, stalls and the verdict.
module testbench;
  import roe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 16;
  localparam int LIMIT    = 600000;
  localparam int DRAIN    = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [RHO_W-1:0]        rho_left = '0, rho_right = '0;
  logic signed [VEL_W-1:0] u_left = '0, v_left = '0, u_right = '0, v_right = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] flux_mass, flux_normal_momentum, flux_tangential_momentum;
  logic invalid;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int   errors, pending;
  int   cycles = 0;
  // when set, neither side idles: back-to-back beats
  logic busy_run = 1'b0;

  roe_isothermal_interface_flux #(.FRAC_BITS(FRAC)) u_dut (.*);

  roe_flux_checker #(.FRAC_BITS(FRAC)) u_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_gap();
    return busy_run ? 0 : $urandom_range(0, 9);
  endfunction

  // result side: stall for a drawn number of cycles, then take one beat
  initial begin
    int  n;
    logic v;
    @(negedge rst);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do begin
        @(negedge clk);
        v = result_valid;
        @(posedge clk);
      end while (!v);
    end
  end

  // one item beat; valid stays high across back-to-back beats
  task automatic send_interface(logic [RHO_W-1:0] rl, logic [31:0] ul, logic [31:0] vl,
                                logic [RHO_W-1:0] rr, logic [31:0] ur, logic [31:0] vr);
    int   n;
    logic st;
    n = draw_gap();
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item_valid <= 1'b1;
    rho_left <= rl; u_left <= ul; v_left <= vl;
    rho_right <= rr; u_right <= ur; v_right <= vr;
    do begin
      @(negedge clk);
      st = item_stall;
      @(posedge clk);
    end while (st);
  endtask

  // APB write: setup then access; register takes the value on the access edge
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold valid low and let every expected beat come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [RHO_W-1:0] pick_rho();
    case ($urandom_range(0, 9))
      0:       return RHO_W'($urandom());                        // full range
      1:       return RHO_W'($urandom_range(0, 3));              // zero and tiny
      default: return RHO_W'($urandom_range(1 << 12, 50 << FRAC)); // physical
    endcase
  endfunction

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      default: return 32'($signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC));
    endcase
  endfunction

  task automatic random_batch(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) busy_run = ($urandom_range(0, 3) == 0);
      send_interface(pick_rho(), pick_vel(), pick_vel(),
                     pick_rho(), pick_vel(), pick_vel());
    end
    busy_run = 1'b0;
    drain();
  endtask

  initial begin
    logic [31:0] cs_list[6];
    cs_list = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000,
                32'h0003_4000, 32'h0000_0000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset sound speed: density extremes, zero densities, extreme velocities
    send_interface('0, 32'sd1 << FRAC, '0, 31'd1 << FRAC, '0, '0);
    send_interface(31'd1 << FRAC, '0, '0, '0, '0, '0);
    send_interface('0, '0, '0, '0, '0, '0);
    send_interface(31'd1 << FRAC, '0, '0, 31'd1 << FRAC, '0, '0);
    send_interface(31'd1, '0, '0, 31'd1, '0, '0);
    send_interface('1, '0, '0, '1, '0, '0);
    send_interface('1, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_interface(31'd1, 32'h8000_0000, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_interface(31'd2 << FRAC, 32'sd3 << FRAC, -(32'sd1 << FRAC),
                   31'd1 << FRAC, -(32'sd2 << FRAC), 32'sd5 << FRAC);
    send_interface(31'd4 << FRAC, 32'sd2 << FRAC, '0, 31'd4 << FRAC, 32'sd2 << FRAC, '0);
    send_interface(31'd1 << FRAC, -(32'sd2 << FRAC), 32'sd1, 31'd9 << FRAC,
                   -(32'sd2 << FRAC), -32'sd1);
    send_interface('1, 32'hFFFF_FFFF, 32'h0000_0001, '1, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();
    random_batch(150);

    // sweep sound speed, zero and both extremes included; a write to an unused
    // register index must leave the speed alone
    foreach (cs_list[k]) begin
      apb_write({REG_SOUND_SPEED, 2'b00}, cs_list[k]);
      if (k == 3) apb_write({~REG_SOUND_SPEED, 2'b00}, $urandom());
      send_interface(31'd1 << FRAC, '0, '0, 31'd2 << FRAC, 32'sd1 << FRAC, '0);
      send_interface('1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 32'h8000_0000, 32'h8000_0000);
      random_batch(k == 5 ? 100 : 160);
    end
    apb_write({REG_SOUND_SPEED, 2'b00}, $urandom());
    random_batch(100);

    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
